// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/adll_pkg.sv -----
// shared types and constants for the array doubly linked list block
// no dependencies; used by all modules of the block
package adll_pkg;

  // default configuration
  localparam int unsigned SLOTS_DEF     = 128;
  localparam int unsigned CODE_BITS_DEF = 64;

  // 8-bit encoding of "no slot"
  localparam logic [7:0] SLOT_NONE = 8'hFF;

  // requested operation
  typedef enum logic [1:0] {
    ACT_HEAD  = 2'd0,
    ACT_AFTER = 2'd1,
    ACT_TAIL  = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIX,
    ST_SUCC,
    ST_DONE
  } state_e;

  // input item
  typedef struct packed {
    action_e            action;
    logic signed [7:0]  slot;
    logic [63:0]        code_a;
    logic [63:0]        code_b;
  } adll_in_t;

  // result item
  typedef struct packed {
    logic               accepted;
    logic signed [7:0]  slot_index;
    logic signed [7:0]  list_head;
    logic signed [7:0]  list_tail;
    logic [7:0]         entry_count;
    logic signed [7:0]  entry_next;
    logic signed [7:0]  entry_prev;
    logic [63:0]        entry_code_a;
    logic [63:0]        entry_code_b;
  } adll_out_t;

endpackage

// ----- src/adll_store.sv -----
// slot storage: link memory {next, prev} and payload memory {code_a, code_b}
// depends on adll_pkg; one write and one registered read per memory per cycle
module adll_store import adll_pkg::*; #(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned CODE_BITS = CODE_BITS_DEF,
  localparam int unsigned IW       = $clog2(SLOTS),
  localparam int unsigned LW       = IW + 1
) (
  input  logic                   clk_i,
  input  logic                   link_we_i,
  input  logic [IW-1:0]          link_waddr_i,
  input  logic [2*LW-1:0]        link_wdata_i,
  input  logic                   link_re_i,
  input  logic [IW-1:0]          link_raddr_i,
  output logic [2*LW-1:0]        link_rdata_o,
  input  logic                   pay_we_i,
  input  logic                   pay_re_i,
  input  logic [IW-1:0]          pay_addr_i,
  input  logic [2*CODE_BITS-1:0] pay_wdata_i,
  output logic [2*CODE_BITS-1:0] pay_rdata_o
);

  logic [2*LW-1:0]        link_mem [SLOTS];
  logic [2*CODE_BITS-1:0] pay_mem  [SLOTS];
  logic [2*LW-1:0]        link_rdata_q;
  logic [2*CODE_BITS-1:0] pay_rdata_q;

  // link memory
  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (link_re_i) begin
      link_rdata_q <= link_mem[link_raddr_i];
    end
  end

  // payload memory
  always_ff @(posedge clk_i) begin
    if (pay_we_i) begin
      pay_mem[pay_addr_i] <= pay_wdata_i;
    end
    if (pay_re_i) begin
      pay_rdata_q <= pay_mem[pay_addr_i];
    end
  end

  assign link_rdata_o = link_rdata_q;
  assign pay_rdata_o  = pay_rdata_q;

endmodule

// ----- src/array_doubly_linked_list.sv -----
// Doubly linked list in a fixed pool of SLOTS slots, with links and payload held in
// synchronous memories. Entries are never removed, so the slots in use are always
// 0..count-1 and the lowest free slot is the entry count itself; no clearing pass is
// needed after reset. One item is worked on at a time, paced by the single read and
// single write port of the link memory: a read, a rejected insert or an insert
// into an empty list goes from idle to done; any other insert passes the fix state,
// and an insert after a slot (or at the tail) whose new entry has a successor also
// the succ state. A finished result sits in an output register; the next item is
// taken once that result has been loaded. Depends on adll_pkg and adll_store.
module array_doubly_linked_list import adll_pkg::*; #(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned CODE_BITS = CODE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  adll_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output adll_out_t out_data_o
);

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam int unsigned LW   = IW + 1;
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;
  localparam logic [LW-1:0] LINK_NONE = {1'b1, {IW{1'b0}}};

  // link helpers: top bit flags "no slot"
  function automatic logic [7:0] idx8(input logic [IW-1:0] idx);
    logic [IW+7:0] ext;
    ext = (IW+8)'(idx);
    return ext[7:0];
  endfunction

  function automatic logic [7:0] link8(input logic [LW-1:0] lnk);
    return lnk[IW] ? SLOT_NONE : idx8(lnk[IW-1:0]);
  endfunction

  function automatic logic [7:0] cnt8(input logic [CW-1:0] cnt);
    logic [CW+7:0] ext;
    ext = (CW+8)'(cnt);
    return ext[7:0];
  endfunction

  state_e state_q, state_d;

  logic [LW-1:0]        head_q, tail_q;
  logic [CW-1:0]        count_q;
  logic                 ins_q, after_q, ok_q;
  logic [IW-1:0]        new_q, tgt_q, res_slot_q;
  logic [LW-1:0]        new_next_q, new_prev_q;
  logic [CODE_BITS-1:0] code_a_q, code_b_q;
  adll_out_t            out_q, out_d;
  logic                 out_valid_q;

  // memory ports
  logic                   link_we, link_re, pay_we, pay_re;
  logic [IW-1:0]          link_waddr, link_raddr, pay_addr;
  logic [2*LW-1:0]        link_wdata, link_rdata;
  logic [2*CODE_BITS-1:0] pay_wdata, pay_rdata;
  logic [LW-1:0]          rd_next, rd_prev;

  // accept decode
  logic          accept, out_free, done_go;
  logic          slot_ok, free, head_empty, is_read, head_mode, after_mode, ins_ok;
  logic [IW-1:0] slot_idx, pred, new_idx;

  assign rd_next = link_rdata[2*LW-1:LW];
  assign rd_prev = link_rdata[LW-1:0];

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign done_go  = (state_q == ST_DONE) && out_free;

  always_comb begin
    slot_ok    = !in_data_i.slot[7] &&
                 (CMPW'(in_data_i.slot[6:0]) < CMPW'(count_q));
    slot_idx   = IW'(in_data_i.slot[6:0]);
    free       = count_q < CW'(SLOTS);
    new_idx    = count_q[IW-1:0];
    head_empty = head_q[IW];
    is_read    = in_data_i.action == ACT_READ;
    head_mode  = (in_data_i.action == ACT_HEAD) ||
                 ((in_data_i.action == ACT_TAIL) && head_empty);
    after_mode = (in_data_i.action == ACT_AFTER) ||
                 ((in_data_i.action == ACT_TAIL) && !head_empty);
    pred       = (in_data_i.action == ACT_AFTER) ? slot_idx : tail_q[IW-1:0];
    ins_ok     = !is_read && free &&
                 (head_mode || ((in_data_i.action == ACT_AFTER) ? slot_ok : 1'b1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (ins_ok && (after_mode || !head_empty)) begin
            state_d = ST_FIX;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FIX: begin
        if (after_q && !rd_next[IW]) begin
          state_d = ST_SUCC;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SUCC: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and memory controls
  always_comb begin
    in_ready_o = 1'b0;
    link_we    = 1'b0;
    link_waddr = tgt_q;
    link_wdata = {rd_next, 1'b0, new_q};
    link_re    = 1'b0;
    link_raddr = rd_next[IW-1:0];
    pay_we     = 1'b0;
    pay_re     = 1'b0;
    pay_addr   = slot_idx;
    pay_wdata  = {in_data_i.code_a[CODE_BITS-1:0], in_data_i.code_b[CODE_BITS-1:0]};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        link_re    = accept;
        link_raddr = is_read ? slot_idx : (after_mode ? pred : head_q[IW-1:0]);
        pay_re     = accept && is_read;
        pay_we     = accept && ins_ok;
        pay_addr   = is_read ? slot_idx : new_idx;
      end
      ST_FIX: begin
        // head mode: old head gets new prev; after mode: pred gets new next
        link_we    = 1'b1;
        link_waddr = tgt_q;
        link_wdata = after_q ? {1'b0, new_q, rd_prev} : {rd_next, 1'b0, new_q};
        link_re    = after_q && !rd_next[IW];
        link_raddr = rd_next[IW-1:0];
      end
      ST_SUCC: begin
        // successor gets new prev
        link_we    = 1'b1;
        link_waddr = new_next_q[IW-1:0];
        link_wdata = {rd_next, 1'b0, new_q};
      end
      ST_DONE: begin
        // links of the new entry
        link_we    = ins_q && out_free;
        link_waddr = new_q;
        link_wdata = {new_next_q, new_prev_q};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= LINK_NONE;
      tail_q      <= LINK_NONE;
      count_q     <= '0;
      ins_q       <= 1'b0;
      after_q     <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        after_q <= after_mode;
        if (is_read) begin
          ok_q  <= slot_ok;
          ins_q <= 1'b0;
        end else if (ins_ok) begin
          ok_q    <= 1'b1;
          ins_q   <= 1'b1;
          count_q <= count_q + CW'(1);
          if (head_mode) begin
            head_q <= {1'b0, new_idx};
            if (head_empty) begin
              tail_q <= {1'b0, new_idx};
            end
          end
        end else begin
          ok_q  <= 1'b0;
          ins_q <= 1'b0;
        end
      end
      // new entry after the old tail becomes the tail
      if ((state_q == ST_FIX) && after_q && rd_next[IW]) begin
        tail_q <= {1'b0, new_q};
      end
      if (done_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_q      <= new_idx;
      res_slot_q <= slot_idx;
      code_a_q   <= in_data_i.code_a[CODE_BITS-1:0];
      code_b_q   <= in_data_i.code_b[CODE_BITS-1:0];
      if (head_mode) begin
        tgt_q      <= head_q[IW-1:0];
        new_next_q <= head_q;
        new_prev_q <= LINK_NONE;
      end else begin
        tgt_q      <= pred;
        new_prev_q <= {1'b0, pred};
      end
    end
    if ((state_q == ST_FIX) && after_q) begin
      new_next_q <= rd_next;
    end
    if (done_go) begin
      out_q <= out_d;
    end
  end

  // result assembly
  always_comb begin
    out_d.accepted     = ok_q;
    out_d.list_head    = link8(head_q);
    out_d.list_tail    = link8(tail_q);
    out_d.entry_count  = cnt8(count_q);
    out_d.slot_index   = SLOT_NONE;
    out_d.entry_next   = SLOT_NONE;
    out_d.entry_prev   = SLOT_NONE;
    out_d.entry_code_a = '0;
    out_d.entry_code_b = '0;
    if (ok_q && ins_q) begin
      out_d.slot_index   = idx8(new_q);
      out_d.entry_next   = link8(new_next_q);
      out_d.entry_prev   = link8(new_prev_q);
      out_d.entry_code_a = 64'(code_a_q);
      out_d.entry_code_b = 64'(code_b_q);
    end else if (ok_q) begin
      out_d.slot_index   = idx8(res_slot_q);
      out_d.entry_next   = link8(rd_next);
      out_d.entry_prev   = link8(rd_prev);
      out_d.entry_code_a = 64'(pay_rdata[2*CODE_BITS-1:CODE_BITS]);
      out_d.entry_code_b = 64'(pay_rdata[CODE_BITS-1:0]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  adll_store #(
    .SLOTS    (SLOTS),
    .CODE_BITS(CODE_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .link_we_i   (link_we),
    .link_waddr_i(link_waddr),
    .link_wdata_i(link_wdata),
    .link_re_i   (link_re),
    .link_raddr_i(link_raddr),
    .link_rdata_o(link_rdata),
    .pay_we_i    (pay_we),
    .pay_re_i    (pay_re),
    .pay_addr_i  (pay_addr),
    .pay_wdata_i (pay_wdata),
    .pay_rdata_o (pay_rdata)
  );

endmodule

// ----- src/adll_checker.sv -----
// port-level assertions for the array doubly linked list block, bound to the top level
// depends on adll_pkg and assert_macros.svh
`include "assert_macros.svh"

module adll_checker import adll_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input adll_out_t out_data_o
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed while stalled")

  // one item at a time: no item taken right after another
  `ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "item taken while busy")

  // rejected result reports no slot and no links
  `ASSERT_NOW(a_reject_fields, clk_i, rst_ni, out_valid_o && !out_data_o.accepted, (out_data_o.slot_index == SLOT_NONE) && (out_data_o.entry_next == SLOT_NONE) && (out_data_o.entry_prev == SLOT_NONE), "rejected result carries a slot")

  // empty head and empty tail agree with an empty count
  `ASSERT_NOW(a_empty_list, clk_i, rst_ni, out_valid_o && (SLOTS < 255) && (out_data_o.list_head == SLOT_NONE), (out_data_o.list_tail == SLOT_NONE) && (out_data_o.entry_count == 8'd0), "head empty but tail or count not")

endmodule

bind array_doubly_linked_list adll_checker #(.SLOTS(SLOTS)) u_adll_checker (.*);
